/* rtl/core/kqsb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kqsb_pkg: shared definitions for the shared-buffer queue block
// Operation and status codes, default sizes, and the controller/datapath
// command and status groups.
// ----------------------------------------------------------------------------
package kqsb_pkg;

    localparam int DATA_W       = 32;
    localparam int QID_W        = 2;
    localparam int STATUS_W     = 2;
    localparam int SLOTS_DEF    = 16;
    localparam int QUEUES_DEF   = 4;

    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic accept;   // word taken, first reads issued
        logic fetch;    // dequeue: read link and data at the head slot
        logic commit;   // apply updates and load the result register
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic deq_go;   // word on the input is a dequeue that will succeed
        logic out_free; // result register can take a word this cycle
    } ctrl_stat_t;

endpackage

/* rtl/core/kqsb_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kqsb_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds without rd_en.
// ----------------------------------------------------------------------------
module kqsb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/kqsb_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kqsb_ctrl: sequencer for the shared-buffer queue block
// Takes one word at a time; pointer fetch (successful dequeues only), then commit.
// ----------------------------------------------------------------------------
module kqsb_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  kqsb_pkg::ctrl_stat_t stat,
    output kqsb_pkg::ctrl_cmd_t  ctl
);

    import kqsb_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_COMMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_stall_reg;
    logic   in_stall_next;

    always_comb
    begin
        ctl.accept = in_valid && !in_stall_reg;
        ctl.fetch  = (state_reg == S_FETCH);
        ctl.commit = (state_reg == S_COMMIT) && stat.out_free;

        state_next    = state_reg;
        in_stall_next = in_stall_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (ctl.accept)
                begin
                    state_next    = stat.deq_go ? S_FETCH : S_COMMIT;
                    in_stall_next = 1'b1;
                end
            end
            S_FETCH:
            begin
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (stat.out_free)
                begin
                    state_next    = S_IDLE;
                    in_stall_next = 1'b0;
                end
            end
            default:
            begin
                state_next    = S_IDLE;
                in_stall_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            in_stall_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            in_stall_reg <= in_stall_next;
        end
    end

    assign in_stall = in_stall_reg;

endmodule

/* rtl/core/kqsb_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kqsb_datapath: pointer registers, link/data/head/tail RAMs, result register
// Free list head, head valid bits and the fresh-slot watermark live here.
// ----------------------------------------------------------------------------
module kqsb_datapath #(
    parameter int SLOTS  = kqsb_pkg::SLOTS_DEF,
    parameter int QUEUES = kqsb_pkg::QUEUES_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cmd,
    input  logic [kqsb_pkg::QID_W-1:0]           queue_id,
    input  logic signed [kqsb_pkg::DATA_W-1:0]   data_in,
    input  kqsb_pkg::ctrl_cmd_t                  ctl,
    output kqsb_pkg::ctrl_stat_t                 stat,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [kqsb_pkg::DATA_W-1:0]   data_out,
    output logic [kqsb_pkg::STATUS_W-1:0]        status
);

    import kqsb_pkg::*;

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int PTR_W  = $clog2(SLOTS + 1);
    localparam int QA_W   = (QUEUES > 1) ? $clog2(QUEUES) : 1;
    localparam int QW     = (QA_W > QID_W) ? QA_W : QID_W;
    localparam logic [PTR_W-1:0] NIL      = PTR_W'(SLOTS);
    localparam logic [QW:0]      QUEUES_N = (QW + 1)'(QUEUES);

    // input decode
    logic [QW-1:0]   q_wide;
    logic [QA_W-1:0] q_addr;
    logic            in_range;
    logic            ok_now;

    // latched word
    logic              cmd_reg;
    logic [QA_W-1:0]   q_reg;
    logic [DATA_W-1:0] data_reg;
    logic              ok_reg;

    // pointer state
    logic [PTR_W-1:0]  free_head_reg, free_head_next;
    logic [PTR_W-1:0]  wm_reg, wm_next;          // slots at or above are untouched
    logic [QUEUES-1:0] head_valid_reg, head_valid_next;

    // link read side
    logic              link_rd_en;
    logic [SLOT_W-1:0] link_rd_addr;
    logic [PTR_W-1:0]  rd_ptr;
    logic              link_fresh_reg;
    logic [PTR_W-1:0]  link_succ_reg;
    logic [PTR_W-1:0]  link_rd;
    logic [PTR_W-1:0]  next_ptr;

    // RAM read data
    logic [SLOT_W-1:0] head_rd;
    logic [SLOT_W-1:0] tail_rd;
    logic [DATA_W-1:0] data_rd;

    // commit side
    logic              do_enq, do_deq;
    logic              q_empty, is_last;
    logic [SLOT_W-1:0] slot_new;
    logic              link_wr_en;
    logic [SLOT_W-1:0] link_wr_addr;
    logic [PTR_W-1:0]  link_wr_data;
    logic              head_wr_en;
    logic [SLOT_W-1:0] head_wr_data;

    // result register
    logic                out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]   data_out_reg;
    logic [STATUS_W-1:0] status_reg;

    always_comb
    begin
        q_wide   = QW'(queue_id);
        q_addr   = q_wide[QA_W-1:0];
        in_range = ({1'b0, q_wide} < QUEUES_N);
        stat.deq_go   = (cmd == CMD_DEQ) && in_range && head_valid_reg[q_addr];
        stat.out_free = !out_valid_reg || !out_stall;
        ok_now = (cmd == CMD_ENQ) ? (in_range && (free_head_reg < NIL)) : stat.deq_go;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            cmd_reg  <= cmd;
            q_reg    <= q_addr;
            data_reg <= data_in;
            ok_reg   <= ok_now;
        end
        if (link_rd_en)
        begin
            link_fresh_reg <= (rd_ptr >= wm_reg);
            link_succ_reg  <= rd_ptr + PTR_W'(1);
        end
    end

    // untouched slots still chain to their successor
    always_comb
    begin
        link_rd_en   = ctl.accept || ctl.fetch;
        link_rd_addr = ctl.fetch ? head_rd : free_head_reg[SLOT_W-1:0];
        rd_ptr       = ctl.fetch ? PTR_W'(head_rd) : free_head_reg;
        next_ptr     = link_fresh_reg ? link_succ_reg : link_rd;
    end

    always_comb
    begin
        do_enq   = ctl.commit && ok_reg && (cmd_reg == CMD_ENQ);
        do_deq   = ctl.commit && ok_reg && (cmd_reg == CMD_DEQ);
        slot_new = free_head_reg[SLOT_W-1:0];
        q_empty  = !head_valid_reg[q_reg];
        is_last  = (head_rd == tail_rd);

        link_wr_en   = (do_enq && !q_empty) || do_deq;
        link_wr_addr = do_deq ? head_rd : tail_rd;
        link_wr_data = do_deq ? free_head_reg : PTR_W'(slot_new);

        head_wr_en   = (do_enq && q_empty) || (do_deq && !is_last);
        head_wr_data = do_deq ? next_ptr[SLOT_W-1:0] : slot_new;

        free_head_next  = free_head_reg;
        wm_next         = wm_reg;
        head_valid_next = head_valid_reg;
        if (do_enq)
        begin
            free_head_next = next_ptr;
            if (free_head_reg >= wm_reg)
            begin
                wm_next = wm_reg + PTR_W'(1);
            end
            if (q_empty)
            begin
                head_valid_next[q_reg] = 1'b1;
            end
        end
        if (do_deq)
        begin
            free_head_next = PTR_W'(head_rd);
            if (is_last)
            begin
                head_valid_next[q_reg] = 1'b0;
            end
        end

        out_valid_next = out_valid_reg && out_stall;
        if (ctl.commit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_head_reg  <= '0;
            wm_reg         <= '0;
            head_valid_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            free_head_reg  <= free_head_next;
            wm_reg         <= wm_next;
            head_valid_reg <= head_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.commit)
        begin
            data_out_reg <= (ok_reg && (cmd_reg == CMD_DEQ)) ? data_rd : '0;
            if (ok_reg)
            begin
                status_reg <= ST_OK;
            end
            else
            begin
                status_reg <= (cmd_reg == CMD_ENQ) ? ST_FULL : ST_EMPTY;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign data_out  = data_out_reg;
    assign status    = status_reg;

    kqsb_ram #(.WIDTH(DATA_W), .DEPTH(SLOTS)) u_data_ram (
        .clk     (clk),
        .wr_en   (do_enq),
        .wr_addr (slot_new),
        .wr_data (data_reg),
        .rd_en   (ctl.fetch),
        .rd_addr (head_rd),
        .rd_data (data_rd)
    );

    kqsb_ram #(.WIDTH(PTR_W), .DEPTH(SLOTS)) u_link_ram (
        .clk     (clk),
        .wr_en   (link_wr_en),
        .wr_addr (link_wr_addr),
        .wr_data (link_wr_data),
        .rd_en   (link_rd_en),
        .rd_addr (link_rd_addr),
        .rd_data (link_rd)
    );

    kqsb_ram #(.WIDTH(SLOT_W), .DEPTH(QUEUES)) u_head_ram (
        .clk     (clk),
        .wr_en   (head_wr_en),
        .wr_addr (q_reg),
        .wr_data (head_wr_data),
        .rd_en   (ctl.accept),
        .rd_addr (q_addr),
        .rd_data (head_rd)
    );

    kqsb_ram #(.WIDTH(SLOT_W), .DEPTH(QUEUES)) u_tail_ram (
        .clk     (clk),
        .wr_en   (do_enq),
        .wr_addr (q_reg),
        .wr_data (slot_new),
        .rd_en   (ctl.accept),
        .rd_addr (q_addr),
        .rd_data (tail_rd)
    );

endmodule

/* rtl/core/k_queues_shared_buffer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// k_queues_shared_buffer: several FIFO queues in one shared slot store
//
// Input channel (in_valid / in_stall) carries one word per operation:
// cmd selects enqueue or dequeue, queue_id picks the queue, data_in is
// the word to append. Output channel (out_valid / out_stall) returns one
// word per operation: data_out (dequeued word, else 0) and status
// (ok, store full, queue empty). Out-of-range queue numbers fail.
//
// Sequencing: one operation in flight. An enqueue or a failing operation
// goes from accept to commit; a successful dequeue has a fetch state in
// between: the head pointer read must finish before the link and data
// RAMs can be read at that slot. A new word is taken the cycle after the
// result is loaded. The result register holds while out_stall is high;
// the next word is still accepted, its commit waiting until it frees up.
//
// Reset: all queues empty, free list chains every slot in order. No
// clearing pass: a watermark marks slots never touched, whose link reads
// as the next slot index.
// ----------------------------------------------------------------------------
module k_queues_shared_buffer #(
    parameter int SLOTS  = kqsb_pkg::SLOTS_DEF,
    parameter int QUEUES = kqsb_pkg::QUEUES_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 cmd,
    input  logic [kqsb_pkg::QID_W-1:0]           queue_id,
    input  logic signed [kqsb_pkg::DATA_W-1:0]   data_in,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [kqsb_pkg::DATA_W-1:0]   data_out,
    output logic [kqsb_pkg::STATUS_W-1:0]        status
);

    import kqsb_pkg::*;

    ctrl_cmd_t  ctl;
    ctrl_stat_t stat;

    // sequencer: accept -> (fetch) -> commit
    kqsb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .ctl      (ctl)
    );

    // pointers, RAMs and the result register
    kqsb_datapath #(
        .SLOTS  (SLOTS),
        .QUEUES (QUEUES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .queue_id  (queue_id),
        .data_in   (data_in),
        .ctl       (ctl),
        .stat      (stat),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .data_out  (data_out),
        .status    (status)
    );

    // busy right after taking a word
    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.accept |=> in_stall)
        else $error("input not stalled after accept");

    // commit always lands in the result register
    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.commit |=> out_valid)
        else $error("result lost at commit");

    // failed operations return a zero word
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != ST_OK)) |-> (data_out == '0))
        else $error("nonzero data on failed operation");

    // commit only when the result register can take it
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> !ctl.commit)
        else $error("commit overwrote a stalled result");

endmodule

/* tb/k_queues_shared_buffer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// k_queues_shared_buffer_tb: self-checking bench for the shared-buffer queues
// Drives enqueue and dequeue words through the valid/stall input channel and
// predicts every reply with a local linked-list copy of the slot store.
// Replies are checked in order, field by field. Traffic runs through several
// idle/stall mixes, plus one long receiver hold-off that backs up the block.
// ----------------------------------------------------------------------------
module k_queues_shared_buffer_tb;

    import kqsb_pkg::*;

    localparam int SLOTS     = SLOTS_DEF;
    localparam int QUEUES    = QUEUES_DEF;
    localparam int PTR_W     = $clog2(SLOTS + 1);
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int WDOG_MAX  = 2000;   // cycles with no word moving on either side
    localparam int HOLD_LEN  = 150;    // long receiver hold-off
    localparam int CHUNK     = 32;     // words per random traffic mix

    typedef logic [PTR_W-1:0] ptr_t;
    localparam ptr_t NIL = ptr_t'(SLOTS);

    // one expected reply
    typedef struct {
        logic signed [DATA_W-1:0] data_out;
        logic [STATUS_W-1:0]      status;
    } reply_t;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic                       cmd;
    logic [QID_W-1:0]           queue_id;
    logic signed [DATA_W-1:0]   data_in;
    logic                       out_valid;
    logic                       out_stall;
    logic signed [DATA_W-1:0]   data_out;
    logic [STATUS_W-1:0]        status;

    // local copy of the block's linked-list state
    logic [DATA_W-1:0] slot_word [SLOTS];
    ptr_t              next_ptr  [SLOTS];
    ptr_t              head_ptr  [QUEUES];
    ptr_t              tail_ptr  [QUEUES];
    ptr_t              free_ptr;

    reply_t reply_q[$];        // replies still owed by the block, oldest first

    int err_count    = 0;
    int in_idle_pct  = 0;      // chance per cycle that the sender idles
    int out_stall_pct = 0;     // chance per cycle that the receiver stalls
    int hold_cycles  = 0;      // pending forced stall cycles

    k_queues_shared_buffer #(
        .SLOTS  (SLOTS),
        .QUEUES (QUEUES)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .queue_id  (queue_id),
        .data_in   (data_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .data_out  (data_out),
        .status    (status)
    );

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor: applies one operation to the local lists, returns the reply.
    // Enqueue pops the free list and links the slot after the queue's tail;
    // dequeue unlinks the head and pushes the slot on the front of the free
    // list. A pointer at or past SLOTS counts as null.
    // ------------------------------------------------------------------------
    function automatic reply_t apply_queue_op(input logic op, input logic [QID_W-1:0] q,
                                              input logic [DATA_W-1:0] word);
        reply_t r;
        ptr_t   slot;
        ptr_t   nxt;
        r.data_out = '0;
        r.status   = ST_OK;
        if (op == CMD_ENQ)
        begin
            slot = free_ptr;
            if (int'(q) >= QUEUES || slot >= SLOTS)
                r.status = ST_FULL;         // no free slot (or no such queue)
            else
            begin
                free_ptr = next_ptr[slot[SLOT_W-1:0]];
                if (head_ptr[q] >= SLOTS)
                    head_ptr[q] = slot;     // queue was empty
                else if (tail_ptr[q] < SLOTS)
                    next_ptr[tail_ptr[q][SLOT_W-1:0]] = slot;
                next_ptr[slot[SLOT_W-1:0]]  = NIL;
                tail_ptr[q]                 = slot;
                slot_word[slot[SLOT_W-1:0]] = word;
            end
        end
        else
        begin
            slot = (int'(q) < QUEUES) ? head_ptr[q] : NIL;
            if (slot >= SLOTS)
                r.status = ST_EMPTY;
            else
            begin
                nxt = next_ptr[slot[SLOT_W-1:0]];
                if (nxt >= SLOTS)
                begin
                    // last word leaves: tail goes null as well
                    head_ptr[q] = NIL;
                    tail_ptr[q] = NIL;
                end
                else
                    head_ptr[q] = nxt;
                next_ptr[slot[SLOT_W-1:0]] = free_ptr;
                free_ptr                   = slot;
                r.data_out                 = slot_word[slot[SLOT_W-1:0]];
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Sender: called at a rising edge. Optionally idles, then offers the word
    // and holds it until an edge sees valid high and stall low. The reply is
    // predicted at that edge.
    // ------------------------------------------------------------------------
    task automatic send_word(input logic op, input logic [QID_W-1:0] q,
                             input logic [DATA_W-1:0] word);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= op;
        queue_id <= q;
        data_in  <= word;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        reply_q.push_back(apply_queue_op(op, q, word));
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stall per cycle; a hold-off request forces stall high
    // while hold_cycles, counted down here, stays above zero.
    // ------------------------------------------------------------------------
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                out_stall <= 1'b1;
                hold_cycles--;
            end
            else
                out_stall <= ($urandom_range(99) < out_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Reply checker: every word taken from the output is compared with the
    // oldest prediction. Values are sampled at the edge, before any update.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        reply_t want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (reply_q.size() == 0)
            begin
                $error("reply: unexpected word, data_out %0d status %0d", data_out, status);
                err_count++;
            end
            else
            begin
                want = reply_q.pop_front();
                if (data_out !== want.data_out)
                begin
                    $error("data_out: expected %0d, actual %0d", want.data_out, data_out);
                    err_count++;
                end
                if (status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, status);
                    err_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: ends the run once its quiet count, cleared whenever a word moves
    // on either channel, reaches WDOG_MAX. The long hold-off stays well below that.
    // ------------------------------------------------------------------------
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WDOG_MAX)
        begin
            @(posedge clk);
            if ((in_valid === 1'b1 && in_stall === 1'b0) ||
                (out_valid === 1'b1 && out_stall === 1'b0))
                quiet = 0;
            else
                quiet++;
        end
        $display("k_queues_shared_buffer_tb: errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // dequeue from every queue right after reset: all empty
    task automatic test_empty_queue;
        int i;
        for (i = 0; i < QUEUES; i++)
            send_word(CMD_DEQ, QID_W'(i), $urandom);
    endtask

    // extreme words pass through in order; the second dequeue empties the queue
    task automatic test_fifo_order;
        send_word(CMD_ENQ, 2'd1, 32'h8000_0000);
        send_word(CMD_ENQ, 2'd1, 32'h7FFF_FFFF);
        send_word(CMD_DEQ, 2'd1, 32'h0);
        send_word(CMD_DEQ, 2'd1, 32'hFFFF_FFFF);
    endtask

    // fill every slot, overflow once, then free one slot and reuse it
    task automatic test_store_full;
        int i;
        logic [DATA_W-1:0] w;
        for (i = 0; i < SLOTS; i++)
        begin
            w = (i == 0) ? 32'h0 : (i == 1) ? 32'hFFFF_FFFF : $urandom;
            send_word(CMD_ENQ, QID_W'(i % QUEUES), w);
        end
        send_word(CMD_ENQ, 2'd0, $urandom);
        send_word(CMD_DEQ, 2'd2, $urandom);
        send_word(CMD_ENQ, 2'd2, $urandom);
    endtask

    // receiver holds off for a long stretch while the sender keeps offering
    task automatic test_backpressure;
        int i;
        in_idle_pct   = 0;
        out_stall_pct = 0;
        hold_cycles   = HOLD_LEN;
        for (i = 0; i < 12; i++)
            send_word(logic'($urandom_range(1)), QID_W'($urandom_range(QUEUES - 1)), $urandom);
    endtask

    // Random traffic in chunks. Each chunk picks an enqueue bias so the store
    // both fills up and drains, and a favored queue so single lists grow
    // long. Some chunks run with no idling at all.
    task automatic test_random(input int n_words, input int idle_pct, input int stall_pct);
        int   i;
        int   enq_bias;
        int   favored;
        logic calm;
        logic op;
        logic [QID_W-1:0] q;
        enq_bias = 50;
        favored  = 0;
        for (i = 0; i < n_words; i++)
        begin
            if (i % CHUNK == 0)
            begin
                case ($urandom_range(2))
                    0:       enq_bias = 85;
                    1:       enq_bias = 50;
                    default: enq_bias = 15;
                endcase
                favored       = $urandom_range(QUEUES - 1);
                calm          = ($urandom_range(3) == 0);
                in_idle_pct   = calm ? 0 : idle_pct;
                out_stall_pct = calm ? 0 : stall_pct;
            end
            op = ($urandom_range(99) < enq_bias) ? CMD_ENQ : CMD_DEQ;
            q  = $urandom_range(1) ? QID_W'(favored) : QID_W'($urandom_range(QUEUES - 1));
            send_word(op, q, $urandom);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int i;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        cmd      = CMD_ENQ;
        queue_id = '0;
        data_in  = '0;

        // reset image: all queues empty, every slot chained on the free list
        for (i = 0; i < SLOTS; i++)
        begin
            slot_word[i] = '0;
            next_ptr[i]  = (i + 1 < SLOTS) ? ptr_t'(i + 1) : NIL;
        end
        for (i = 0; i < QUEUES; i++)
        begin
            head_ptr[i] = NIL;
            tail_ptr[i] = NIL;
        end
        free_ptr = '0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_queue();
        test_fifo_order();
        test_store_full();
        test_backpressure();
        test_random(175, 0, 0);
        test_random(175, 70, 0);
        test_random(175, 0, 70);
        test_random(175, 26, 26);

        in_valid      <= 1'b0;
        in_idle_pct   = 0;
        out_stall_pct = 0;

        // drain outstanding replies, then watch for stray words
        while (reply_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (err_count == 0)
            $display("k_queues_shared_buffer_tb: clean");
        else
            $display("k_queues_shared_buffer_tb: errors");
        $finish;
    end

endmodule

/* files.f */
rtl/core/kqsb_pkg.sv
rtl/core/kqsb_ram.sv
rtl/core/kqsb_ctrl.sv
rtl/core/kqsb_datapath.sv
rtl/core/k_queues_shared_buffer.sv
tb/k_queues_shared_buffer_tb.sv
